### sv/vgm_csd_pkg.sv
`default_nettype none

package vgm_csd_pkg;

    // header bytes that the decode stage looks at (offsets 0 to 10)
    localparam int SNAP_BYTES = 11;

    typedef logic [7:0]  t_byte;
    typedef logic [32:0] t_len;

    // opcodes with a meaning of their own
    localparam t_byte OP_PSG          = 8'h50;
    localparam t_byte OP_FM_PORT0     = 8'h52;
    localparam t_byte OP_FM_PORT1     = 8'h53;
    localparam t_byte OP_WAIT_16      = 8'h61;
    localparam t_byte OP_WAIT_NTSC    = 8'h62;
    localparam t_byte OP_WAIT_PAL     = 8'h63;
    localparam t_byte OP_END          = 8'h66;
    localparam t_byte OP_DATA_BLOCK   = 8'h67;
    localparam t_byte OP_WRITE_BLOCK  = 8'h68;
    localparam t_byte OP_STREAM_FIRST = 8'h90;
    localparam t_byte OP_STREAM_DATA  = 8'h91;
    localparam t_byte OP_STREAM_FREQ  = 8'h92;
    localparam t_byte OP_STREAM_START = 8'h93;
    localparam t_byte OP_STREAM_FAST  = 8'h95;
    localparam t_byte OP_SEEK         = 8'hE0;
    localparam logic [3:0] OP_HI_SHORT_WAIT = 4'h7;
    localparam logic [3:0] OP_HI_PCM_WAIT   = 4'h8;

    // fixed header sizes of the two block commands
    localparam int DATA_BLOCK_HDR  = 7;
    localparam int WRITE_BLOCK_HDR = 12;

    // decode constants
    localparam logic [15:0] WAIT_NTSC    = 16'h02DF;
    localparam logic [15:0] WAIT_PAL     = 16'h0372;
    localparam t_byte       PSG_ENV_MASK = 8'h91;
    localparam t_byte       FM_KEY_REG   = 8'h28;
    localparam logic [2:0]  CH_NONE      = 3'd7;
    localparam logic [2:0]  KEY_BAD_LO   = 3'd3;
    localparam logic [2:0]  KEY_BAD_HI   = 3'd7;
    localparam logic [2:0]  FM_PORT1_OFS = 3'd3;

    // kind codes
    localparam logic [4:0] KIND_OTHER      = 5'd0;
    localparam logic [4:0] KIND_PSG_TONE   = 5'd1;
    localparam logic [4:0] KIND_PSG_ENV    = 5'd2;
    localparam logic [4:0] KIND_FM_PORT0   = 5'd3;
    localparam logic [4:0] KIND_FM_PORT1   = 5'd4;
    localparam logic [4:0] KIND_KEY_ON     = 5'd5;
    localparam logic [4:0] KIND_KEY_OFF    = 5'd6;
    localparam logic [4:0] KIND_WAIT_SHORT = 5'd7;
    localparam logic [4:0] KIND_WAIT_16    = 5'd8;
    localparam logic [4:0] KIND_WAIT_NTSC  = 5'd9;
    localparam logic [4:0] KIND_WAIT_PAL   = 5'd10;
    localparam logic [4:0] KIND_WAIT_PCM   = 5'd11;
    localparam logic [4:0] KIND_DATA_BLOCK = 5'd12;
    localparam logic [4:0] KIND_END        = 5'd13;
    localparam logic [4:0] KIND_SEEK       = 5'd14;
    localparam logic [4:0] KIND_STREAM     = 5'd15;

    // completed command handed from the tracker to the decode stage
    typedef struct packed {
        t_byte [SNAP_BYTES-1:0] hdr;
        t_len                   length;
    } t_cmd;

    // decoded record
    typedef struct packed {
        t_byte       opcode;
        t_len        command_length;
        logic [15:0] wait_samples;
        logic [4:0]  kind;
        t_byte       chip_register;
        t_byte       chip_value;
        logic [2:0]  fm_channel;
        logic [2:0]  key_channel;
        t_byte       stream_id;
        t_byte       short_argument;
        logic [31:0] long_argument;
        logic [31:0] sample_size;
    } t_record;

endpackage

`default_nettype wire

### sv/vgm_csd_byte_if.sv
`default_nettype none

interface vgm_csd_byte_if;
    import vgm_csd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

### sv/vgm_csd_rec_if.sv
`default_nettype none

interface vgm_csd_rec_if;
    import vgm_csd_pkg::*;

    logic        valid;
    logic        ready;
    t_byte       opcode;
    t_len        command_length;
    logic [15:0] wait_samples;
    logic [4:0]  kind;
    t_byte       chip_register;
    t_byte       chip_value;
    logic [2:0]  fm_channel;
    logic [2:0]  key_channel;
    t_byte       stream_id;
    t_byte       short_argument;
    logic [31:0] long_argument;
    logic [31:0] sample_size;

    modport source (
        output valid, output opcode, output command_length, output wait_samples,
        output kind, output chip_register, output chip_value, output fm_channel,
        output key_channel, output stream_id, output short_argument,
        output long_argument, output sample_size, input ready
    );
    modport sink (
        input valid, input opcode, input command_length, input wait_samples,
        input kind, input chip_register, input chip_value, input fm_channel,
        input key_channel, input stream_id, input short_argument,
        input long_argument, input sample_size, output ready
    );
endinterface

`default_nettype wire

### sv/vgm_csd_tracker.sv
`default_nettype none

module vgm_csd_tracker #(
    parameter int HEADER_BYTES = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    vgm_csd_byte_if.sink          i_in,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output vgm_csd_pkg::t_cmd     o_cmd
);
    import vgm_csd_pkg::*;

    localparam int IDX_W = $clog2(HEADER_BYTES);

    // command length from the opcode alone
    function automatic logic [3:0] fixed_length(input t_byte op);
        logic [3:0] len;
        case (op) inside
            8'h4F, 8'h50:                       len = 4'd2;
            8'h61:                              len = 4'd3;
            8'h62, 8'h63, 8'h66:                len = 4'd1;
            8'h67:                              len = 4'd7;
            8'h68:                              len = 4'd12;
            8'h90, 8'h91:                       len = 4'd5;
            8'h92:                              len = 4'd6;
            8'h93:                              len = 4'd11;
            8'h94:                              len = 4'd2;
            8'h95:                              len = 4'd5;
            [8'h51:8'h5F]:                      len = 4'd3;
            [8'h30:8'h3F]:                      len = 4'd2;
            [8'h40:8'h4F]:                      len = 4'd3;
            [8'hA0:8'hBF]:                      len = 4'd3;
            [8'hC0:8'hDF]:                      len = 4'd4;
            [8'hE0:8'hFF]:                      len = 4'd5;
            default:                            len = 4'd1;
        endcase
        return len;
    endfunction

    t_byte r_hdr [HEADER_BYTES];
    t_len  r_pos;
    t_len  r_exp;
    logic  r_cvalid;
    t_cmd  r_cmd;

    t_len  n_pos;
    t_len  n_exp;
    t_cmd  n_cmd;
    t_len  pos_inc;
    t_byte b;
    logic  in_ready;
    logic  accept;
    logic  done;

    // handshake: one completed command can wait in the snapshot register
    assign in_ready = !r_cvalid || i_ready;
    assign i_in.ready = in_ready;
    assign accept = i_in.valid && in_ready;
    assign b = i_in.stream_byte;

    // expected length, position and completion
    always_comb begin
        n_exp = r_exp;
        if (r_pos == '0) begin
            n_exp = 33'(fixed_length(b));
        end else if (r_hdr[0] == OP_DATA_BLOCK && r_pos == 33'd6) begin
            n_exp = 33'(DATA_BLOCK_HDR) + {1'b0, b, r_hdr[5], r_hdr[4], r_hdr[3]};
        end else if (r_hdr[0] == OP_WRITE_BLOCK && r_pos == 33'd11) begin
            n_exp = 33'(WRITE_BLOCK_HDR) + {9'b0, b, r_hdr[10], r_hdr[9]};
        end
        pos_inc = r_pos + 33'd1;
        done = (pos_inc >= n_exp);
        n_pos = done ? '0 : pos_inc;
    end

    // snapshot of the header with the current byte merged in
    always_comb begin
        for (int k = 0; k < SNAP_BYTES; k++) begin
            n_cmd.hdr[k] = (r_pos == 33'(k)) ? b : r_hdr[k];
        end
        n_cmd.length = n_exp;
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (accept && r_pos < 33'(HEADER_BYTES)) begin
            r_hdr[r_pos[IDX_W-1:0]] <= b;
        end
    end

    // position tracking and snapshot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_exp    <= '0;
            r_cvalid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
                r_exp <= n_exp;
            end
            if (accept && done) begin
                r_cvalid <= 1'b1;
            end else if (i_ready) begin
                r_cvalid <= 1'b0;
            end
        end
    end

    // snapshot payload
    always_ff @(posedge i_clk) begin
        if (accept && done) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_cvalid;
    assign o_cmd   = r_cmd;

endmodule

`default_nettype wire

### sv/vgm_csd_decoder.sv
`default_nettype none

module vgm_csd_decoder (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire vgm_csd_pkg::t_cmd i_cmd,
    vgm_csd_rec_if.source         o_out
);
    import vgm_csd_pkg::*;

    // little-endian 32-bit field at a fixed offset
    function automatic logic [31:0] le32(input t_byte [SNAP_BYTES-1:0] h, input int k);
        return {h[k+3], h[k+2], h[k+1], h[k]};
    endfunction

    t_record r_rec;
    logic    r_valid;
    t_record n_rec;
    t_byte   op;
    t_byte   b1;
    t_byte   b2;
    logic [2:0] key_c;
    logic    accept;

    assign o_ready = !r_valid || o_out.ready;
    assign accept  = i_valid && o_ready;

    assign op    = i_cmd.hdr[0];
    assign b1    = i_cmd.hdr[1];
    assign b2    = i_cmd.hdr[2];
    assign key_c = b2[2:0];

    // opcode decode
    always_comb begin
        n_rec                = '0;
        n_rec.opcode         = op;
        n_rec.command_length = i_cmd.length;
        n_rec.kind           = KIND_OTHER;
        n_rec.fm_channel     = CH_NONE;
        n_rec.key_channel    = CH_NONE;
        if (op[7:4] == OP_HI_SHORT_WAIT) begin
            n_rec.kind         = KIND_WAIT_SHORT;
            n_rec.wait_samples = 16'(op[3:0]) + 16'd1;
        end else if (op[7:4] == OP_HI_PCM_WAIT) begin
            n_rec.kind         = KIND_WAIT_PCM;
            n_rec.wait_samples = 16'(op[3:0]);
        end else if (op == OP_WAIT_16) begin
            n_rec.kind         = KIND_WAIT_16;
            n_rec.wait_samples = {b2, b1};
        end else if (op == OP_WAIT_NTSC) begin
            n_rec.kind         = KIND_WAIT_NTSC;
            n_rec.wait_samples = WAIT_NTSC;
        end else if (op == OP_WAIT_PAL) begin
            n_rec.kind         = KIND_WAIT_PAL;
            n_rec.wait_samples = WAIT_PAL;
        end else if (op == OP_PSG) begin
            n_rec.chip_register = b1;
            n_rec.kind = ((b1 & PSG_ENV_MASK) == PSG_ENV_MASK) ? KIND_PSG_ENV : KIND_PSG_TONE;
        end else if (op == OP_FM_PORT0 || op == OP_FM_PORT1) begin
            n_rec.chip_register = b1;
            n_rec.chip_value    = b2;
            n_rec.fm_channel    = {1'b0, b1[1:0]} + ((op == OP_FM_PORT1) ? FM_PORT1_OFS : 3'd0);
            n_rec.kind          = (op == OP_FM_PORT1) ? KIND_FM_PORT1 : KIND_FM_PORT0;
            if (op == OP_FM_PORT0 && b1 == FM_KEY_REG) begin
                n_rec.kind = (b2[7:4] != 4'd0) ? KIND_KEY_ON : KIND_KEY_OFF;
                if (key_c != KEY_BAD_LO && key_c != KEY_BAD_HI) begin
                    n_rec.key_channel = key_c[2] ? key_c - 3'd1 : key_c;
                end
            end
        end else if (op == OP_DATA_BLOCK) begin
            n_rec.kind           = KIND_DATA_BLOCK;
            n_rec.short_argument = b2;
            n_rec.long_argument  = le32(i_cmd.hdr, 3);
        end else if (op == OP_END) begin
            n_rec.kind = KIND_END;
        end else if (op == OP_SEEK) begin
            n_rec.kind          = KIND_SEEK;
            n_rec.long_argument = le32(i_cmd.hdr, 1);
        end else if (op >= OP_STREAM_FIRST && op <= OP_STREAM_FAST) begin
            n_rec.kind      = KIND_STREAM + 5'(op[2:0]);
            n_rec.stream_id = b1;
            if (op == OP_STREAM_DATA || op == OP_STREAM_FAST) begin
                n_rec.short_argument = b2;
            end else if (op == OP_STREAM_FREQ) begin
                n_rec.long_argument = le32(i_cmd.hdr, 2);
            end else if (op == OP_STREAM_START) begin
                n_rec.long_argument = le32(i_cmd.hdr, 2);
                n_rec.sample_size   = le32(i_cmd.hdr, 7);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rec <= n_rec;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.opcode         = r_rec.opcode;
    assign o_out.command_length = r_rec.command_length;
    assign o_out.wait_samples   = r_rec.wait_samples;
    assign o_out.kind           = r_rec.kind;
    assign o_out.chip_register  = r_rec.chip_register;
    assign o_out.chip_value     = r_rec.chip_value;
    assign o_out.fm_channel     = r_rec.fm_channel;
    assign o_out.key_channel    = r_rec.key_channel;
    assign o_out.stream_id      = r_rec.stream_id;
    assign o_out.short_argument = r_rec.short_argument;
    assign o_out.long_argument  = r_rec.long_argument;
    assign o_out.sample_size    = r_rec.sample_size;

endmodule

`default_nettype wire

### sv/vgm_command_stream_decoder_unit.sv
// VGM command stream decoder
// Input channel i_byte carries one stream byte per transaction. The block
// tracks the byte position inside the current command, keeps the first
// HEADER_BYTES bytes of it, and works out the command length from the
// opcode (data blocks and write data blocks from their length fields).
// Payload bytes are counted and dropped.
// Output channel o_record carries one decoded record per completed command.
// Throughput: one byte per cycle while the snapshot register can move on, with
// the position counter update (a 33-bit increment and compare) in the tracker.
// Pipeline: two register stages (header snapshot, then decode output); a
// record's last byte is taken into the snapshot, then decoded into the output.
// Reset puts the block at a command boundary with no record pending.
// When the receiver stalls, one record waits in the output register and one
// more in the snapshot register; the byte input is then held off until the
// snapshot register can move on.
`default_nettype none

module vgm_command_stream_decoder_unit #(
    parameter int HEADER_BYTES = 12
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    vgm_csd_byte_if.sink   i_byte,
    vgm_csd_rec_if.source  o_record
);
    import vgm_csd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // byte position tracking and header capture
    vgm_csd_tracker #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_byte),
        .o_valid (cmd_valid),
        .i_ready (cmd_ready),
        .o_cmd   (cmd)
    );

    // record decode
    vgm_csd_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cmd_valid),
        .o_ready (cmd_ready),
        .i_cmd   (cmd),
        .o_out   (o_record)
    );

    // a record never reports an empty command
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_record.valid |-> o_record.command_length != '0)
        else $error("record with zero command length");

    // fm channel is given exactly for fm writes and key writes
    a_fm_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_record.valid |-> ((o_record.fm_channel != CH_NONE) ==
            (o_record.kind == KIND_FM_PORT0 || o_record.kind == KIND_FM_PORT1 ||
             o_record.kind == KIND_KEY_ON || o_record.kind == KIND_KEY_OFF)))
        else $error("fm channel does not match kind");

    // key channel only on key writes
    a_key_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_record.valid && o_record.key_channel != CH_NONE) |->
            (o_record.kind == KIND_KEY_ON || o_record.kind == KIND_KEY_OFF))
        else $error("key channel on a non-key record");

    // nonzero wait only on wait commands
    a_wait_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_record.valid && o_record.wait_samples != '0) |->
            (o_record.kind == KIND_WAIT_SHORT || o_record.kind == KIND_WAIT_16 ||
             o_record.kind == KIND_WAIT_NTSC || o_record.kind == KIND_WAIT_PAL ||
             o_record.kind == KIND_WAIT_PCM))
        else $error("wait samples on a non-wait record");

endmodule

`default_nettype wire
